// ===== rtl/gpio_pkg.sv =====
`timescale 1ns / 1ps

package gpio_pkg;

   localparam int NUM_PINS_DEFAULT = 32;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_EVENT = 2'd2;

   localparam logic [9:0] OFS_ID    = 10'h000;
   localparam logic [9:0] OFS_PARAM = 10'h001;
   localparam logic [9:0] OFS_DATA  = 10'h010;
   localparam logic [9:0] OFS_SET   = 10'h011;
   localparam logic [9:0] OFS_CLR   = 10'h012;
   localparam logic [9:0] OFS_TOG   = 10'h013;
   localparam logic [9:0] OFS_PAD   = 10'h014;
   localparam logic [9:0] OFS_DIR   = 10'h015;
   localparam logic [9:0] OFS_FLAGS = 10'h048;
   localparam logic [9:0] OFS_FEN   = 10'h050;
   localparam logic [9:0] OFS_FCLK  = 10'h051;
   localparam logic [9:0] OFS_FWID  = 10'h052;

   localparam logic [4:0] CTRL_PAGE = 5'd1;

   localparam logic [31:0] ID_VALUE    = 32'h0201_0001;
   localparam logic [31:0] PARAM_VALUE = 32'h0000_0002;

   localparam int TRIG_LSB = 16;
   localparam int TRIG_W   = 4;

   localparam logic [3:0] TRIG_LOW  = 4'h8;
   localparam logic [3:0] TRIG_RISE = 4'h9;
   localparam logic [3:0] TRIG_FALL = 4'ha;
   localparam logic [3:0] TRIG_BOTH = 4'hb;
   localparam logic [3:0] TRIG_HIGH = 4'hc;

   localparam int UPPER_LSB = 16;

   typedef struct packed {
      logic [1:0]  op;
      logic [9:0]  word_offset;
      logic [31:0] write_data;
      logic [4:0]  pin_index;
      logic        pin_level;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [31:0] pin_drive;
      logic        irq_any;
      logic        irq_upper;
   } rsp_type;

endpackage

// ===== rtl/gpio_req_reg.sv =====
`timescale 1ns / 1ps

module gpio_req_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gpio_pkg::req_type req_item,
   input  logic             take,
   output logic             hold_valid,
   output gpio_pkg::req_type hold_item
);

   logic             valid_ff;
   logic             valid_in;
   gpio_pkg::req_type item_ff;

   assign req_ready  = !valid_ff || take;
   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== rtl/gpio_regs.sv =====
`timescale 1ns / 1ps

module gpio_regs #(
   parameter int NUM_PINS = gpio_pkg::NUM_PINS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  gpio_pkg::req_type item,
   output gpio_pkg::rsp_type result
);

   localparam int IDX_W = $clog2(NUM_PINS);
   localparam logic [5:0] PIN_COUNT = 6'(NUM_PINS);

   logic [NUM_PINS-1:0] data_ff;
   logic [NUM_PINS-1:0] data_in;
   logic [NUM_PINS-1:0] dir_ff;
   logic [NUM_PINS-1:0] dir_in;
   logic [NUM_PINS-1:0] lev_ff;
   logic [NUM_PINS-1:0] lev_in;
   logic [NUM_PINS-1:0] flag_ff;
   logic [NUM_PINS-1:0] flag_in;
   logic [31:0]         fen_ff;
   logic [31:0]         fen_in;
   logic [31:0]         fclk_ff;
   logic [31:0]         fclk_in;
   logic [31:0]         fwid_ff;
   logic [31:0]         fwid_in;
   logic [31:0]         ctrl_ff [NUM_PINS];
   logic [3:0]          trig_ff [NUM_PINS];

   logic                ctrl_we;
   logic                is_ctrl;
   logic                ctrl_ok;
   logic                ev_ok;
   logic [IDX_W-1:0]    ctrl_pin;
   logic [IDX_W-1:0]    ev_pin;
   logic [NUM_PINS-1:0] wdata;
   logic [3:0]          new_trig;
   logic [3:0]          ev_trig;
   logic                old_lvl;
   logic                cur_lvl;
   logic                hit;
   logic [31:0]         rd;

   assign is_ctrl  = item.word_offset[9:5] == gpio_pkg::CTRL_PAGE;
   assign ctrl_ok  = is_ctrl && ({1'b0, item.word_offset[4:0]} < PIN_COUNT);
   assign ev_ok    = {1'b0, item.pin_index} < PIN_COUNT;
   assign ctrl_pin = item.word_offset[IDX_W-1:0];
   assign ev_pin   = item.pin_index[IDX_W-1:0];
   assign wdata    = item.write_data[NUM_PINS-1:0];
   assign new_trig = item.write_data[gpio_pkg::TRIG_LSB +: gpio_pkg::TRIG_W];
   assign ev_trig  = trig_ff[ev_pin];
   assign old_lvl  = lev_ff[ev_pin];
   assign cur_lvl  = lev_ff[ctrl_pin];

   always_comb begin
      unique case (ev_trig)
         gpio_pkg::TRIG_LOW:  hit = !item.pin_level;
         gpio_pkg::TRIG_RISE: hit = !old_lvl && item.pin_level;
         gpio_pkg::TRIG_FALL: hit = old_lvl && !item.pin_level;
         gpio_pkg::TRIG_BOTH: hit = old_lvl != item.pin_level;
         gpio_pkg::TRIG_HIGH: hit = item.pin_level;
         default:             hit = 1'b0;
      endcase
   end

   always_comb begin
      data_in = data_ff;
      dir_in  = dir_ff;
      lev_in  = lev_ff;
      flag_in = flag_ff;
      fen_in  = fen_ff;
      fclk_in = fclk_ff;
      fwid_in = fwid_ff;
      ctrl_we = 1'b0;
      rd      = '0;
      if (item.op == gpio_pkg::OP_READ) begin
         if (is_ctrl) begin
            rd = ctrl_ok ? ctrl_ff[ctrl_pin] : '0;
         end else begin
            unique case (item.word_offset)
               gpio_pkg::OFS_ID:    rd = gpio_pkg::ID_VALUE;
               gpio_pkg::OFS_PARAM: rd = gpio_pkg::PARAM_VALUE;
               gpio_pkg::OFS_DATA:  rd = 32'(data_ff);
               gpio_pkg::OFS_PAD:   rd = 32'((data_ff & dir_ff) | (lev_ff & ~dir_ff));
               gpio_pkg::OFS_DIR:   rd = 32'(dir_ff);
               gpio_pkg::OFS_FLAGS: rd = 32'(flag_ff);
               gpio_pkg::OFS_FEN:   rd = fen_ff;
               gpio_pkg::OFS_FCLK:  rd = fclk_ff;
               gpio_pkg::OFS_FWID:  rd = fwid_ff;
               default:             rd = '0;
            endcase
         end
      end else if (item.op == gpio_pkg::OP_WRITE) begin
         if (is_ctrl) begin
            if (ctrl_ok) begin
               ctrl_we = 1'b1;
               if ((new_trig == gpio_pkg::TRIG_LOW && !cur_lvl) ||
                   (new_trig == gpio_pkg::TRIG_HIGH && cur_lvl)) begin
                  flag_in[ctrl_pin] = 1'b1;
               end
            end
         end else begin
            unique case (item.word_offset)
               gpio_pkg::OFS_DATA:  data_in = wdata;
               gpio_pkg::OFS_SET:   data_in = data_ff | wdata;
               gpio_pkg::OFS_CLR:   data_in = data_ff & ~wdata;
               gpio_pkg::OFS_TOG:   data_in = data_ff ^ wdata;
               gpio_pkg::OFS_DIR:   dir_in  = wdata;
               gpio_pkg::OFS_FLAGS: flag_in = flag_ff & ~wdata;
               gpio_pkg::OFS_FEN:   fen_in  = item.write_data;
               gpio_pkg::OFS_FCLK:  fclk_in = item.write_data;
               gpio_pkg::OFS_FWID:  fwid_in = item.write_data;
               default:             ;
            endcase
         end
      end else if (item.op == gpio_pkg::OP_EVENT) begin
         if (ev_ok) begin
            lev_in[ev_pin] = item.pin_level;
            if (hit) begin
               flag_in[ev_pin] = 1'b1;
            end
         end
      end
   end

   assign result.read_data = rd;
   assign result.pin_drive = 32'(data_in & dir_in);
   assign result.irq_any   = |flag_in;
   assign result.irq_upper = |flag_in[NUM_PINS-1:gpio_pkg::UPPER_LSB];

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
         dir_ff  <= '0;
         lev_ff  <= '1;
         flag_ff <= '0;
         fen_ff  <= '0;
         fclk_ff <= '0;
         fwid_ff <= '0;
         for (int i = 0; i < NUM_PINS; i++) begin
            ctrl_ff[i] <= '0;
            trig_ff[i] <= '0;
         end
      end else if (advance) begin
         data_ff <= data_in;
         dir_ff  <= dir_in;
         lev_ff  <= lev_in;
         flag_ff <= flag_in;
         fen_ff  <= fen_in;
         fclk_ff <= fclk_in;
         fwid_ff <= fwid_in;
         if (ctrl_we) begin
            ctrl_ff[ctrl_pin] <= item.write_data;
            trig_ff[ctrl_pin] <= new_trig;
         end
      end
   end

   // Flags only ever fall through a write-one-to-clear access.
   a_flags_sticky: assert property (@(posedge clock) disable iff (reset)
      !(advance && item.op == gpio_pkg::OP_WRITE && item.word_offset == gpio_pkg::OFS_FLAGS)
      |=> (flag_ff & $past(flag_ff)) == $past(flag_ff))
      else $error("interrupt flag cleared without a clear access");

   a_levels_event_only: assert property (@(posedge clock) disable iff (reset)
      !(advance && item.op == gpio_pkg::OP_EVENT) |=> $stable(lev_ff))
      else $error("input levels changed without a pin event");

   a_data_write_only: assert property (@(posedge clock) disable iff (reset)
      !(advance && item.op == gpio_pkg::OP_WRITE) |=> $stable(data_ff) && $stable(dir_ff))
      else $error("output data or direction changed without a write");

endmodule

// ===== rtl/gpio_rsp_reg.sv =====
`timescale 1ns / 1ps

module gpio_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  gpio_pkg::rsp_type load_item,
   output logic              can_load,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gpio_pkg::rsp_type rsp_item
);

   logic              valid_ff;
   logic              valid_in;
   gpio_pkg::rsp_type item_ff;

   assign can_load  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

endmodule

// ===== rtl/gpio_port_with_pin_interrupts.sv =====
`timescale 1ns / 1ps
// Flow: an accepted item waits in the input register; its result is computed as it leaves and
// is held in the result register.
// Throughput: one item per cycle while the result register can load; register state is updated
// in one pass as the item leaves the input register, so the next item sees it at once.
// Reset: synchronous and active high; clears both stages, outputs and direction to zero, flags to
// zero, control words and filter registers to zero and input levels to all ones.
module gpio_port_with_pin_interrupts #(
   parameter int NUM_PINS = gpio_pkg::NUM_PINS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gpio_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gpio_pkg::rsp_type rsp_item
);

   logic              hold_valid;
   gpio_pkg::req_type hold_item;
   gpio_pkg::rsp_type step_result;
   logic              can_load;
   logic              advance;

   assign advance = hold_valid && can_load;

   gpio_req_reg u_req_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (advance),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   gpio_regs #(
      .NUM_PINS (NUM_PINS)
   ) u_regs (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (hold_item),
      .result  (step_result)
   );

   gpio_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_item (step_result),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== bench/gpio_port_with_pin_interrupts_tb.sv =====
`timescale 1ns / 1ps

module gpio_port_with_pin_interrupts_tb;

   localparam int PINS = gpio_pkg::NUM_PINS_DEFAULT;
   localparam logic [31:0] PIN_MASK = 32'hffff_ffff >> (32 - PINS);
   localparam logic [1:0] OP_NONE = 2'd3;
   localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
   localparam logic [9:0] OFS_UNMAPPED = 10'h3ff;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE_CYCLES = 10;
   localparam int unsigned CYCLE_LIMIT = 300000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   gpio_pkg::req_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   gpio_pkg::rsp_type rsp_item;

   logic tx_idle_on = 1'b1;
   logic rx_idle_on = 1'b1;
   logic hold_request = 1'b0;
   int fail_count = 0;
   int unsigned cycle_count = 0;

   // Port state as the block should hold it.
   logic [31:0] m_dout = '0;
   logic [31:0] m_dir = '0;
   logic [31:0] m_lvl = '1;
   logic [31:0] m_flags = '0;
   logic [31:0] m_fen = '0;
   logic [31:0] m_fclk = '0;
   logic [31:0] m_fwid = '0;
   logic [31:0] m_ctrl [32];

   gpio_pkg::rsp_type rsp_due_q [$];

   gpio_port_with_pin_interrupts dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic gpio_pkg::rsp_type predict_port(input gpio_pkg::req_type it);
      gpio_pkg::rsp_type r;
      int unsigned p;
      logic [3:0] trig;
      logic old_lvl;
      logic hit;
      r = '0;
      hit = 1'b0;
      p = 32'((it.op == gpio_pkg::OP_EVENT) ? it.pin_index : it.word_offset[4:0]);
      trig = m_ctrl[p][gpio_pkg::TRIG_LSB +: gpio_pkg::TRIG_W];
      case (it.op)
         gpio_pkg::OP_READ: begin
            if (it.word_offset[9:5] == gpio_pkg::CTRL_PAGE) begin
               r.read_data = (p < PINS) ? m_ctrl[p] : '0;
            end else begin
               case (it.word_offset)
                  gpio_pkg::OFS_ID:    r.read_data = gpio_pkg::ID_VALUE;
                  gpio_pkg::OFS_PARAM: r.read_data = gpio_pkg::PARAM_VALUE;
                  gpio_pkg::OFS_DATA:  r.read_data = m_dout;
                  gpio_pkg::OFS_PAD:   r.read_data =
                     ((m_dout & m_dir) | (m_lvl & ~m_dir)) & PIN_MASK;
                  gpio_pkg::OFS_DIR:   r.read_data = m_dir;
                  gpio_pkg::OFS_FLAGS: r.read_data = m_flags;
                  gpio_pkg::OFS_FEN:   r.read_data = m_fen;
                  gpio_pkg::OFS_FCLK:  r.read_data = m_fclk;
                  gpio_pkg::OFS_FWID:  r.read_data = m_fwid;
                  default:             r.read_data = '0;
               endcase
            end
         end
         gpio_pkg::OP_WRITE: begin
            if (it.word_offset[9:5] == gpio_pkg::CTRL_PAGE) begin
               if (p < PINS) begin
                  m_ctrl[p] = it.write_data;
                  trig = it.write_data[gpio_pkg::TRIG_LSB +: gpio_pkg::TRIG_W];
                  if ((trig == gpio_pkg::TRIG_LOW && !m_lvl[p]) ||
                      (trig == gpio_pkg::TRIG_HIGH && m_lvl[p])) begin
                     m_flags[p] = 1'b1;
                  end
               end
            end else begin
               case (it.word_offset)
                  gpio_pkg::OFS_DATA:  m_dout = it.write_data & PIN_MASK;
                  gpio_pkg::OFS_SET:   m_dout = m_dout | (it.write_data & PIN_MASK);
                  gpio_pkg::OFS_CLR:   m_dout = m_dout & ~it.write_data;
                  gpio_pkg::OFS_TOG:   m_dout = m_dout ^ (it.write_data & PIN_MASK);
                  gpio_pkg::OFS_DIR:   m_dir = it.write_data & PIN_MASK;
                  gpio_pkg::OFS_FLAGS: m_flags = m_flags & ~it.write_data;
                  gpio_pkg::OFS_FEN:   m_fen = it.write_data;
                  gpio_pkg::OFS_FCLK:  m_fclk = it.write_data;
                  gpio_pkg::OFS_FWID:  m_fwid = it.write_data;
                  default: ;
               endcase
            end
         end
         gpio_pkg::OP_EVENT: begin
            if (p < PINS) begin
               old_lvl = m_lvl[p];
               m_lvl[p] = it.pin_level;
               case (trig)
                  gpio_pkg::TRIG_LOW:  hit = !it.pin_level;
                  gpio_pkg::TRIG_RISE: hit = !old_lvl && it.pin_level;
                  gpio_pkg::TRIG_FALL: hit = old_lvl && !it.pin_level;
                  gpio_pkg::TRIG_BOTH: hit = old_lvl != it.pin_level;
                  gpio_pkg::TRIG_HIGH: hit = it.pin_level;
                  default:             hit = 1'b0;
               endcase
               if (hit) begin
                  m_flags[p] = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.pin_drive = m_dout & m_dir & PIN_MASK;
      r.irq_any = |m_flags;
      r.irq_upper = |m_flags[31:gpio_pkg::UPPER_LSB];
      return r;
   endfunction

   function automatic gpio_pkg::req_type port_op(input logic [1:0] op, input logic [9:0] ofs,
                                                 input logic [31:0] data, input logic [4:0] pin,
                                                 input logic lvl);
      gpio_pkg::req_type it;
      it.op = op;
      it.word_offset = ofs;
      it.write_data = data;
      it.pin_index = pin;
      it.pin_level = lvl;
      return it;
   endfunction

   function automatic logic [31:0] trig_word(input logic [3:0] trig, input logic [31:0] rest);
      logic [31:0] w;
      w = rest;
      w[gpio_pkg::TRIG_LSB +: gpio_pkg::TRIG_W] = trig;
      return w;
   endfunction

   function automatic logic [9:0] pick_register();
      case ($urandom_range(0, 13))
         0:  return gpio_pkg::OFS_ID;
         1:  return gpio_pkg::OFS_PARAM;
         2:  return gpio_pkg::OFS_DATA;
         3:  return gpio_pkg::OFS_SET;
         4:  return gpio_pkg::OFS_CLR;
         5:  return gpio_pkg::OFS_TOG;
         6:  return gpio_pkg::OFS_PAD;
         7:  return gpio_pkg::OFS_DIR;
         8:  return gpio_pkg::OFS_FLAGS;
         9:  return gpio_pkg::OFS_FEN;
         10: return gpio_pkg::OFS_FCLK;
         11: return gpio_pkg::OFS_FWID;
         12: return {gpio_pkg::CTRL_PAGE, 5'($urandom)};
         default: return 10'($urandom);
      endcase
   endfunction

   function automatic logic [4:0] focus_pin();
      case ($urandom_range(0, 3))
         0: return 5'($urandom_range(0, 3));
         1: return 5'($urandom_range(28, 31));
         default: return 5'($urandom);
      endcase
   endfunction

   function automatic logic [3:0] pick_trigger();
      case ($urandom_range(0, 5))
         0: return gpio_pkg::TRIG_LOW;
         1: return gpio_pkg::TRIG_RISE;
         2: return gpio_pkg::TRIG_FALL;
         3: return gpio_pkg::TRIG_BOTH;
         4: return gpio_pkg::TRIG_HIGH;
         default: return 4'($urandom);
      endcase
   endfunction

   // Mostly trigger set-up, pin activity and flag service, with a share of arbitrary items.
   function automatic gpio_pkg::req_type random_item();
      gpio_pkg::req_type it;
      int kind;
      it.op = 2'($urandom);
      it.word_offset = 10'($urandom);
      it.write_data = $urandom;
      it.pin_index = 5'($urandom);
      it.pin_level = 1'($urandom);
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         it.op = gpio_pkg::OP_EVENT;
         it.pin_index = focus_pin();
      end else if (kind < 45) begin
         it.op = gpio_pkg::OP_WRITE;
         it.word_offset = {gpio_pkg::CTRL_PAGE, focus_pin()};
         it.write_data[gpio_pkg::TRIG_LSB +: gpio_pkg::TRIG_W] = pick_trigger();
      end else if (kind < 62) begin
         it.op = gpio_pkg::OP_WRITE;
         it.word_offset = pick_register();
      end else if (kind < 85) begin
         it.op = gpio_pkg::OP_READ;
         it.word_offset = pick_register();
      end else if (kind < 92) begin
         it.op = gpio_pkg::OP_WRITE;
         it.word_offset = gpio_pkg::OFS_FLAGS;
      end
      return it;
   endfunction

   task automatic send_item(input gpio_pkg::req_type it);
      req_item <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      rsp_due_q.push_back(predict_port(it));
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (rsp_due_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic test_directed_registers();
      send_item(port_op(gpio_pkg::OP_READ, gpio_pkg::OFS_ID, ALL_ONES, 5'd31, 1'b1));
      send_item(port_op(gpio_pkg::OP_READ, gpio_pkg::OFS_PARAM, '0, 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_READ, gpio_pkg::OFS_PAD, '0, 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_WRITE, gpio_pkg::OFS_ID, ALL_ONES, 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_WRITE, gpio_pkg::OFS_PAD, '0, 5'd0, 1'b0));
      send_item(port_op(OP_NONE, OFS_UNMAPPED, ALL_ONES, 5'd31, 1'b1));
      send_item(port_op(gpio_pkg::OP_WRITE, OFS_UNMAPPED, ALL_ONES, 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_READ, OFS_UNMAPPED, '0, 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_WRITE, gpio_pkg::OFS_DIR, ALL_ONES, 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_WRITE, gpio_pkg::OFS_DATA, ALL_ONES, 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_WRITE, gpio_pkg::OFS_CLR, 32'h0000_ffff, 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_WRITE, gpio_pkg::OFS_TOG, ALL_ONES, 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_WRITE, gpio_pkg::OFS_SET, 32'h0000_0001, 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_WRITE, gpio_pkg::OFS_DIR, 32'h0f0f_0f0f, 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_READ, gpio_pkg::OFS_PAD, '0, 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_WRITE, gpio_pkg::OFS_FEN, ALL_ONES, 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_READ, gpio_pkg::OFS_FEN, '0, 5'd0, 1'b0));
      wait_drained();
   endtask

   task automatic test_directed_triggers();
      send_item(port_op(gpio_pkg::OP_WRITE, {gpio_pkg::CTRL_PAGE, 5'd31},
                        trig_word(gpio_pkg::TRIG_HIGH, 32'h0000_ffff), 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_WRITE, {gpio_pkg::CTRL_PAGE, 5'd0},
                        trig_word(gpio_pkg::TRIG_FALL, '0), 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_EVENT, gpio_pkg::OFS_ID, '0, 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_WRITE, gpio_pkg::OFS_FLAGS, ALL_ONES, 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_WRITE, {gpio_pkg::CTRL_PAGE, 5'd0},
                        trig_word(gpio_pkg::TRIG_LOW, '0), 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_EVENT, gpio_pkg::OFS_ID, '0, 5'd31, 1'b1));
      send_item(port_op(gpio_pkg::OP_WRITE, {gpio_pkg::CTRL_PAGE, 5'd5},
                        trig_word(gpio_pkg::TRIG_RISE, '0), 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_EVENT, gpio_pkg::OFS_ID, '0, 5'd5, 1'b0));
      send_item(port_op(gpio_pkg::OP_EVENT, gpio_pkg::OFS_ID, '0, 5'd5, 1'b1));
      send_item(port_op(gpio_pkg::OP_WRITE, {gpio_pkg::CTRL_PAGE, 5'd6},
                        trig_word(gpio_pkg::TRIG_BOTH, '0), 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_EVENT, gpio_pkg::OFS_ID, '0, 5'd6, 1'b0));
      send_item(port_op(gpio_pkg::OP_WRITE, {gpio_pkg::CTRL_PAGE, 5'd7},
                        trig_word(4'hf, ALL_ONES), 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_EVENT, gpio_pkg::OFS_ID, '0, 5'd7, 1'b0));
      send_item(port_op(gpio_pkg::OP_READ, gpio_pkg::OFS_FLAGS, '0, 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_READ, {gpio_pkg::CTRL_PAGE, 5'd31}, '0, 5'd0, 1'b0));
      send_item(port_op(gpio_pkg::OP_WRITE, gpio_pkg::OFS_FLAGS, 32'h8000_0000, 5'd0, 1'b0));
      wait_drained();
   endtask

   task automatic test_random_traffic(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            tx_idle_on = 1'($urandom_range(0, 3) != 0);
            rx_idle_on = 1'($urandom_range(0, 3) != 0);
         end
         send_item(random_item());
      end
      wait_drained();
   endtask

   task automatic test_backpressure(input int count);
      tx_idle_on = 1'b0;
      hold_request = 1'b1;
      for (int i = 0; i < count; i++) begin
         send_item(random_item());
      end
      wait_drained();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   task automatic test_pause_and_drain(input int rounds);
      for (int r = 0; r < rounds; r++) begin
         for (int i = 0; i < 20; i++) begin
            send_item(random_item());
         end
         wait_drained();
      end
   endtask

   task automatic test_steady_stream(input int count);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      for (int i = 0; i < count; i++) begin
         send_item(random_item());
      end
      wait_drained();
   endtask

   always begin
      @(posedge clock);
      if (hold_request) begin
         hold_request = 1'b0;
         rsp_ready <= 1'b0;
         repeat (LONG_HOLD) @(posedge clock);
         rsp_ready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      gpio_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_due_q.size() == 0) begin
            if (fail_count < 10) begin
               $display("unexpected result: read_data %h pin_drive %h irq_any %b irq_upper %b",
                        rsp_item.read_data, rsp_item.pin_drive, rsp_item.irq_any,
                        rsp_item.irq_upper);
            end
            fail_count++;
         end else begin
            want = rsp_due_q.pop_front();
            if (rsp_item.read_data !== want.read_data || rsp_item.pin_drive !== want.pin_drive
                || rsp_item.irq_any !== want.irq_any || rsp_item.irq_upper !== want.irq_upper)
            begin
               if (fail_count < 10) begin
                  $display("mismatch: expected read_data %h pin_drive %h irq_any %b irq_upper %b",
                           want.read_data, want.pin_drive, want.irq_any, want.irq_upper);
                  $display("          actual   read_data %h pin_drive %h irq_any %b irq_upper %b",
                           rsp_item.read_data, rsp_item.pin_drive, rsp_item.irq_any,
                           rsp_item.irq_upper);
               end
               fail_count++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < 32; i++) begin
         m_ctrl[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_registers();
      test_directed_triggers();
      test_random_traffic(1000);
      test_backpressure(60);
      test_pause_and_drain(4);
      test_steady_stream(300);
      repeat (SETTLE_CYCLES) @(posedge clock);
      fail_count += rsp_due_q.size();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/gpio_pkg.sv
rtl/gpio_req_reg.sv
rtl/gpio_regs.sv
rtl/gpio_rsp_reg.sv
rtl/gpio_port_with_pin_interrupts.sv
bench/gpio_port_with_pin_interrupts_tb.sv
